// ===== rtl/fmul_pkg.sv =====
// Shared constants and types for the single-precision multiplier.
`timescale 1ns / 1ps
package fmul_pkg;
    localparam int unsigned EXP_BIAS = 127;
    localparam int unsigned EXP_MAX  = 254;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_OVF  = 2'd1;
    localparam logic [1:0] STATUS_UNF  = 2'd2;

    // Operand stage to result stage.
    typedef struct packed {
        logic        zero;
        logic        sign;
        logic [9:0]  exp_sum;
        logic [47:0] prod;
    } fmul_mid_t;
endpackage

// ===== rtl/fmul_mant.sv =====
// Operand unpack and 24x24 significand multiply.
`timescale 1ns / 1ps
module fmul_mant (
    input  logic [31:0]        operand_a,
    input  logic [31:0]        operand_b,
    output fmul_pkg::fmul_mid_t mid
);
    import fmul_pkg::*;

    logic [23:0] sig_a;
    logic [23:0] sig_b;

    assign sig_a = {1'b1, operand_a[22:0]};
    assign sig_b = {1'b1, operand_b[22:0]};

    always_comb begin
        mid.zero    = (operand_a[30:0] == 31'd0) || (operand_b[30:0] == 31'd0);
        mid.sign    = operand_a[31] ^ operand_b[31];
        mid.exp_sum = {2'b00, operand_a[30:23]} + {2'b00, operand_b[30:23]};
        mid.prod    = 48'(sig_a) * 48'(sig_b);
    end
endmodule

// ===== rtl/fmul_round.sv =====
// Normalize, round half-up, range check and pack.
`timescale 1ns / 1ps
module fmul_round (
    input  fmul_pkg::fmul_mid_t mid,
    output logic [31:0]        product,
    output logic [1:0]         status
);
    import fmul_pkg::*;

    logic [24:0] sig;
    logic        rbit;
    logic [10:0] exp_adj;
    logic        carry;

    always_comb begin
        if (mid.prod[47]) begin
            sig  = {1'b0, mid.prod[47:24]};
            rbit = mid.prod[23];
        end else begin
            sig  = {1'b0, mid.prod[46:23]};
            rbit = mid.prod[22];
        end
        sig   = sig + 25'(rbit);
        carry = sig[24];
        exp_adj = {1'b0, mid.exp_sum} + 11'(mid.prod[47]) + 11'(carry);
        if (carry) begin
            sig = sig >> 1;
        end
        product = 32'd0;
        status  = STATUS_OK;
        if (mid.zero) begin
            status = STATUS_OK;
        end else if (exp_adj > 11'(EXP_MAX + EXP_BIAS)) begin
            status = STATUS_OVF;
        end else if (exp_adj <= 11'(EXP_BIAS)) begin
            status = STATUS_UNF;
        end else begin
            product = {mid.sign, 8'(exp_adj - 11'(EXP_BIAS)), sig[22:0]};
        end
    end
endmodule

// ===== rtl/float32_multiplier_core.sv =====
// Single-precision multiplier top level: operand register, result register.
// Throughput: one word per cycle, back to back, while m_ready stays high.
// Reset: synchronous active-low aresetn clears both stage valid flags.
// Input ready stays high while the operand stage is empty or can advance.
`timescale 1ns / 1ps
module float32_multiplier_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_operand_a,
    input  logic [31:0] s_operand_b,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_product,
    output logic [1:0]  m_status
);
    import fmul_pkg::*;

    logic        in_valid_reg;
    logic [31:0] a_reg;
    logic [31:0] b_reg;
    logic        out_valid_reg;
    logic [31:0] product_reg;
    logic [1:0]  status_reg;
    fmul_mid_t   mid;
    logic [31:0] product_next;
    logic [1:0]  status_next;
    logic        adv;

    assign adv     = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || adv;

    fmul_mant u_mant (.operand_a(a_reg), .operand_b(b_reg), .mid(mid));

    fmul_round u_round (.mid(mid), .product(product_next), .status(status_next));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (adv) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            a_reg <= s_operand_a;
            b_reg <= s_operand_b;
        end
        if (adv && in_valid_reg) begin
            product_reg <= product_next;
            status_reg  <= status_next;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_product = product_reg;
    assign m_status  = status_reg;

`ifndef ASSERT_OFF
    a_no_status3: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status != 2'd3)) else $error("bad status");
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != STATUS_OK) |-> (m_product == 32'd0))
        else $error("nonzero product on fault");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_product)))
        else $error("result lost under stall");
`endif
endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the single-precision multiplier core.
`timescale 1ns / 1ps
module tb_top;
    import fmul_pkg::*;

    typedef struct {
        logic [31:0] product;
        logic [1:0]  status;
    } fmul_word_t;

    class fmul_scoreboard;
        fmul_word_t pending[$];
        int errors;
        int n_words;
        int n_ovf;
        int n_unf;

        task report_mismatch(string msg);
            errors++;
            if (errors <= 50) $display("mismatch @%0t: %s", $realtime, msg);
        endtask

        function fmul_word_t multiply(logic [31:0] a, logic [31:0] b);
            fmul_word_t r;
            int         e;
            logic [47:0] p;
            logic [24:0] sig;
            r.product = '0;
            r.status  = STATUS_OK;
            if (a[30:0] == 0 || b[30:0] == 0) return r;
            e = int'(a[30:23]) + int'(b[30:23]) - int'(EXP_BIAS);
            p = {24'd0, 1'b1, a[22:0]} * {24'd0, 1'b1, b[22:0]};
            if (p[47]) begin
                e++;
                sig = {1'b0, p[47:24]} + 25'(p[23]);
            end else begin
                sig = {1'b0, p[46:23]} + 25'(p[22]);
            end
            if (sig[24]) begin
                sig = sig >> 1;
                e++;
            end
            if (e > int'(EXP_MAX)) r.status = STATUS_OVF;
            else if (e <= 0) r.status = STATUS_UNF;
            else r.product = {a[31] ^ b[31], e[7:0], sig[22:0]};
            return r;
        endfunction

        function void note_operands(logic [31:0] a, logic [31:0] b);
            pending.push_back(multiply(a, b));
        endfunction

        task check_word(logic [31:0] product, logic [1:0] status);
            fmul_word_t w;
            n_words++;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h/%0d", product, status));
                return;
            end
            w = pending.pop_front();
            if (status == STATUS_OVF) n_ovf++;
            if (status == STATUS_UNF) n_unf++;
            if (product !== w.product)
                report_mismatch($sformatf("product %h, want %h", product, w.product));
            if (status !== w.status)
                report_mismatch($sformatf("status %0d, want %0d", status, w.status));
        endtask
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [31:0] s_operand_a = '0;
    logic [31:0] s_operand_b = '0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [31:0] m_product;
    logic [1:0]  m_status;

    fmul_scoreboard sb = new();
    int  cycles;
    bit  calm;

    localparam int N_RANDOM = 1750;
    localparam int CYCLE_LIMIT = 200000;

    float32_multiplier_core uut (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: random stall bursts, sampled at the edge
    initial begin
        int gap;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) sb.check_word(m_product, m_status);
            if (gap > 0) begin
                gap--;
                m_ready <= 0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                gap = $urandom_range(1, 9);
                m_ready <= 0;
            end else begin
                m_ready <= 1;
            end
        end
    end

    // valid drops only for an idle burst, so back-to-back words keep it high
    task send_pair(logic [31:0] a, logic [31:0] b);
        int gap;
        if (!calm && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 9);
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_operand_a <= a;
        s_operand_b <= b;
        s_valid <= 1;
        do @(posedge aclk); while (!s_ready);
        sb.note_operands(a, b);
    endtask

    function logic [31:0] pick_float(int unsigned kind);
        logic [31:0] f;
        f = $urandom();
        case (kind % 6)
            0: f[30:23] = 8'($urandom_range(100, 154));
            1: f[30:23] = 8'($urandom_range(0, 8));
            2: f[30:23] = 8'($urandom_range(247, 255));
            3: f[30:23] = 8'($urandom_range(60, 70));
            4: f[30:0] = ($urandom_range(0, 3) == 0) ? 31'd0 : f[30:0];
            default: ;
        endcase
        return f;
    endfunction

    initial begin
        logic [31:0] dir_a[$];
        logic [31:0] dir_b[$];
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        dir_a = '{32'h0000_0000, 32'h8000_0000, 32'h3f80_0000, 32'hbfc0_0000,
                  32'h3fff_ffff, 32'h7f7f_ffff, 32'h0080_0000, 32'h7fc0_0000,
                  32'h7f80_0000, 32'h0000_0001, 32'hffff_ffff, 32'h3f80_0001,
                  32'h4000_0000, 32'h3fb5_04f3, 32'h1f80_0000, 32'h5f80_0000,
                  32'h3f80_0000, 32'h4040_0000};
        dir_b = '{32'h4049_0fdb, 32'h3f80_0000, 32'h8000_0000, 32'h3fc0_0000,
                  32'h3fff_ffff, 32'h4000_0000, 32'h0080_0000, 32'hff80_0000,
                  32'h7f80_0000, 32'h0000_0001, 32'hffff_ffff, 32'h3fff_ffff,
                  32'h7f00_0000, 32'h3fb5_04f3, 32'h2000_0000, 32'h5f00_0000,
                  32'h7fff_ffff, 32'h8000_0001};
        foreach (dir_a[i]) send_pair(dir_a[i], dir_b[i]);
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i > N_RANDOM - 200) calm = 1;
            send_pair(pick_float($urandom()), pick_float($urandom()));
        end
        s_valid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (m_valid) sb.report_mismatch("extra word after drain");
        $display("%0d products checked: %0d overflow, %0d underflow, rest normal or zero",
                 sb.n_words, sb.n_ovf, sb.n_unf);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
